@@ rtl/core/pcc_pkg.sv @@
// Shared types, constants and helpers for the path clearance checker.
// Used by path_clearance_checker_unit. No dependencies.
`default_nettype none

package pcc_pkg;

  localparam int COORD_BITS = 24;
  localparam int ID_W       = 16;
  localparam int AXIS_W     = COORD_BITS + 1;       // |p-c|-h, clamped at zero
  localparam int SQ_BITS    = 2 * COORD_BITS + 2;   // squared distance
  localparam int ROOT_W     = 25;                   // reported clearance
  localparam int PIDX_W     = 16;
  localparam int COUNT_W    = 7;                    // reported obstacle count
  localparam int CFG_W      = 24;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 88;

  localparam logic [SQ_BITS-1:0] SQ_ALL_ONES  = {SQ_BITS{1'b1}};
  localparam logic [ROOT_W-1:0]  ROOT_ALL_ONES = {ROOT_W{1'b1}};
  localparam logic [SQ_BITS-1:0] SQRT_BIT0 = SQ_BITS'(1) << (SQ_BITS - 2);
  localparam logic signed [COORD_BITS-1:0] MIN_HALF = COORD_BITS'(16);

  // opcodes (input tuser)
  localparam logic [1:0] OP_UPSERT = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_POINT  = 2'd2;

  // result kinds (output tuser)
  localparam logic [1:0] KIND_BOX_ACK   = 2'd0;
  localparam logic [1:0] KIND_CLEAR_ACK = 2'd1;
  localparam logic [1:0] KIND_VERDICT   = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_EMPTY_ID  = 2'd1;
  localparam logic [1:0] ERR_FULL      = 2'd2;
  localparam logic [1:0] ERR_CLEARANCE = 2'd3;

  // one table entry; also the layout of the input tdata (id in the low bits)
  typedef struct packed {
    logic signed [COORD_BITS-1:0] hy;
    logic signed [COORD_BITS-1:0] hx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cx;
    logic [ID_W-1:0]              id;
  } box_entry_t;

  // result payload; ok sits in bit 0
  typedef struct packed {
    logic [PIDX_W-1:0]  point_count;
    logic               worst_valid;
    logic [PIDX_W-1:0]  worst_point_index;
    logic [ID_W-1:0]    worst_obstacle;
    logic [ROOT_W-1:0]  min_clearance_out;
    logic [COUNT_W-1:0] obstacle_count;
    logic               updated;
    logic [1:0]         error_code;
    logic               ok;
  } result_t;

  function automatic logic signed [COORD_BITS-1:0] clamp_half(
      input logic signed [COORD_BITS-1:0] h);
    return (h < MIN_HALF) ? MIN_HALF : h;
  endfunction

  // max(0, |p - c| - h) on one axis
  function automatic logic [AXIS_W-1:0] axis_dist(
      input logic signed [COORD_BITS-1:0] p,
      input logic signed [COORD_BITS-1:0] c,
      input logic signed [COORD_BITS-1:0] h);
    logic signed [COORD_BITS+1:0] d;
    d = {{2{p[COORD_BITS-1]}}, p} - {{2{c[COORD_BITS-1]}}, c};
    if (d[COORD_BITS+1]) d = -d;
    d = d - {{2{h[COORD_BITS-1]}}, h};
    return (!d[COORD_BITS+1] && (d != '0)) ? d[AXIS_W-1:0] : '0;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/pcc_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module pcc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/path_clearance_checker_unit.sv @@
// Path clearance checker: obstacle box table plus nearest-box distance scan.
// Depends on pcc_pkg and pcc_ram.
//
// Usage:
//  - Requests enter on the s_* stream: tuser is the opcode (upsert box, clear
//    table, path point), tlast marks the last point of a path, tdata carries
//    id, position and half extents. Results leave on m_* with tuser = kind.
//  - min_clearance is written over APB at address 0 (1/16 cm, 0 = no check).
//  - Upsert with a nonzero id: one RAM read per entry looking for the id,
//    then the write. Empty id and clear go straight to the result.
//  - Transit point: one entry per cycle goes through a 3-stage distance
//    pipe (abs/sub, square, sum/compare). First and middle points give
//    no result.
//  - Last point: when the path hit a box, the 25 steps of the bit-serial
//    square root run first, then the verdict.
//  - So the scan over the table or the square root sets the rate;
//    s_tready is high only between requests.
//  - One result register decouples the output: a new request is taken while
//    a result waits; if m_tready stays low the next result waits inside.
//  - Reset empties the table (count only; entries are never read beyond it)
//    and the path state, and clears min_clearance. No clearing pass.
`default_nettype none

module path_clearance_checker_unit #(
  parameter int MAX_OBSTACLES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // obstacle_id[15:0], pos_x[39:16], pos_y[63:40], half_x[87:64], half_y[111:88]
  input  wire logic [111:0] s_tdata,
  input  wire logic [1:0]  s_tuser,   // opcode[1:0]
  input  wire logic        s_tlast,   // last_point
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // ok[0], error_code[2:1], updated[3], obstacle_count[10:4],
  // min_clearance_out[35:11], worst_obstacle[51:36], worst_point_index[67:52],
  // worst_valid[68], point_count[84:69], zero[87:85]
  output logic [87:0]      m_tdata,
  output logic [1:0]       m_tuser    // kind[1:0]
);

  localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);
  localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OBSTACLES);
  localparam int PAD_W = pcc_pkg::OUT_DATA_W - $bits(pcc_pkg::result_t);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_VERD = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state;

  // config
  logic [pcc_pkg::CFG_W-1:0] min_clearance;
  logic cfg_wr;

  // table and path state
  logic [CNT_W-1:0]               box_count;
  logic [pcc_pkg::SQ_BITS-1:0]    best_sq;
  logic [pcc_pkg::ID_W-1:0]       best_id;
  logic [pcc_pkg::PIDX_W-1:0]     best_pidx;
  logic                           best_found;
  logic [pcc_pkg::PIDX_W-1:0]     points_seen;

  // current request
  pcc_pkg::box_entry_t        in_item, in_clamped, cur, rd_entry;
  logic [1:0]                 op_q;
  logic [pcc_pkg::PIDX_W-1:0] cur_idx;
  logic                       s_fire;

  // scan pipe
  logic [CNT_W-1:0]            issue_cnt;
  logic                        issue;
  logic                        rd_v, a_v, b_v;
  logic [IDX_W-1:0]            rd_idx;
  logic [pcc_pkg::AXIS_W-1:0]  ax, ay;
  logic [pcc_pkg::ID_W-1:0]    a_id, b_id;
  logic [pcc_pkg::SQ_BITS-1:0] sqx, sqy, sq_sum;
  logic                        better;
  logic                        scan_done;
  logic                        id_hit;

  // upsert decision
  logic             match_found;
  logic [IDX_W-1:0] match_slot;
  logic             up_done, up_write;
  logic [IDX_W-1:0] up_slot;

  // square root
  logic [pcc_pkg::SQ_BITS-1:0] sqrt_n, sqrt_r, sqrt_bit, sqrt_trial;
  logic                        sqrt_take;

  // verdict
  logic [pcc_pkg::ROOT_W-1:0] v_root;
  logic                       v_pass;

  pcc_pkg::result_t res;
  logic [1:0]       res_kind;
  logic             out_free;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(min_clearance);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_clearance <= '0;
    end else if (cfg_wr) begin
      min_clearance <= pwdata[pcc_pkg::CFG_W-1:0];
    end
  end

  // ---------------------------------------------------------------- input
  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign in_item  = s_tdata;

  always_comb begin
    in_clamped    = in_item;
    in_clamped.hx = pcc_pkg::clamp_half(in_item.hx);
    in_clamped.hy = pcc_pkg::clamp_half(in_item.hy);
  end

  // ---------------------------------------------------------------- table
  // one RAM read per cycle while scanning; write only when an upsert lands
  assign issue   = (state == ST_SCAN) && (issue_cnt < box_count);
  assign up_done = scan_done && (op_q == pcc_pkg::OP_UPSERT);
  assign up_write = up_done && (match_found || (box_count < CNT_MAX));
  assign up_slot  = match_found ? match_slot : box_count[IDX_W-1:0];

  pcc_ram #(
    .WIDTH ($bits(pcc_pkg::box_entry_t)),
    .DEPTH (MAX_OBSTACLES),
    .ADDR_W(IDX_W)
  ) u_table (
    .clk  (clk),
    .we   (up_write),
    .waddr(up_slot),
    .wdata(cur),
    .raddr(issue_cnt[IDX_W-1:0]),
    .rdata(rd_entry)
  );

  // ---------------------------------------------------------------- datapath
  assign id_hit    = rd_v && !match_found && (rd_entry.id == cur.id);
  assign sq_sum    = sqx + sqy;   // each square < 2^48, no carry out
  assign better    = b_v && (sq_sum < best_sq);
  assign scan_done = (state == ST_SCAN) && !issue && !rd_v && !a_v && !b_v;

  assign sqrt_trial = sqrt_r + sqrt_bit;
  assign sqrt_take  = (sqrt_n >= sqrt_trial);

  assign v_root = best_found ? sqrt_r[pcc_pkg::ROOT_W-1:0] : pcc_pkg::ROOT_ALL_ONES;
  assign v_pass = (min_clearance == '0) || !best_found ||
                  (v_root >= {1'b0, min_clearance});

  assign out_free = !m_tvalid || m_tready;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      box_count   <= '0;
      best_sq     <= pcc_pkg::SQ_ALL_ONES;
      best_id     <= '0;
      best_pidx   <= '0;
      best_found  <= 1'b0;
      points_seen <= '0;
      issue_cnt   <= '0;
      rd_v        <= 1'b0;
      a_v         <= 1'b0;
      b_v         <= 1'b0;
      match_found <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      rd_v <= issue;
      a_v  <= rd_v && (op_q == pcc_pkg::OP_POINT);
      b_v  <= a_v;
      if (issue) issue_cnt <= issue_cnt + 1'b1;
      if (id_hit) match_found <= 1'b1;

      // strict less-than keeps the earlier box and the earlier point on ties
      if (better) begin
        best_sq    <= sq_sum;
        best_id    <= b_id;
        best_pidx  <= cur_idx;
        best_found <= 1'b1;
      end

      if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            issue_cnt   <= '0;
            match_found <= 1'b0;
            unique case (s_tuser)
              pcc_pkg::OP_UPSERT: begin
                state <= (in_item.id == '0) ? ST_FIN : ST_SCAN;
              end
              pcc_pkg::OP_CLEAR: begin
                box_count <= '0;
                state     <= ST_FIN;
              end
              pcc_pkg::OP_POINT: begin
                if (points_seen != '1) points_seen <= points_seen + 1'b1;
                if (s_tlast) begin
                  state <= best_found ? ST_SQRT : ST_VERD;
                end else if (points_seen != '0) begin
                  state <= ST_SCAN;
                end
              end
              default: ;  // unknown opcode: dropped, no result
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            if (op_q == pcc_pkg::OP_UPSERT) begin
              if (up_write && !match_found) box_count <= box_count + 1'b1;
              state <= ST_FIN;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_SQRT: begin
          if (sqrt_bit[0]) state <= ST_VERD;
        end
        ST_VERD: begin
          // path state back to its idle values
          best_sq     <= pcc_pkg::SQ_ALL_ONES;
          best_id     <= '0;
          best_pidx   <= '0;
          best_found  <= 1'b0;
          points_seen <= '0;
          state       <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_fire) begin
      cur     <= in_clamped;
      op_q    <= s_tuser;
      cur_idx <= points_seen;
    end

    rd_idx <= issue_cnt[IDX_W-1:0];
    if (id_hit) match_slot <= rd_idx;

    // stage A: per-axis distance outside the box
    ax   <= pcc_pkg::axis_dist(cur.cx, rd_entry.cx, rd_entry.hx);
    ay   <= pcc_pkg::axis_dist(cur.cy, rd_entry.cy, rd_entry.hy);
    a_id <= rd_entry.id;
    // stage B: squares
    sqx  <= ax * ax;
    sqy  <= ay * ay;
    b_id <= a_id;

    // bit-serial integer square root, one result bit (two input bits) per step
    if (s_fire) begin
      sqrt_n   <= best_sq;
      sqrt_r   <= '0;
      sqrt_bit <= pcc_pkg::SQRT_BIT0;
    end else if (state == ST_SQRT) begin
      if (sqrt_take) begin
        sqrt_n <= sqrt_n - sqrt_trial;
        sqrt_r <= (sqrt_r >> 1) + sqrt_bit;
      end else begin
        sqrt_r <= sqrt_r >> 1;
      end
      sqrt_bit <= sqrt_bit >> 2;
    end

    if (s_fire && (s_tuser == pcc_pkg::OP_UPSERT) && (in_item.id == '0)) begin
      res_kind <= pcc_pkg::KIND_BOX_ACK;
      res <= '{error_code: pcc_pkg::ERR_EMPTY_ID,
               obstacle_count: pcc_pkg::COUNT_W'(box_count), default: '0};
    end else if (s_fire && (s_tuser == pcc_pkg::OP_CLEAR)) begin
      res_kind <= pcc_pkg::KIND_CLEAR_ACK;
      res <= '{ok: 1'b1, default: '0};
    end else if (up_done) begin
      res_kind <= pcc_pkg::KIND_BOX_ACK;
      res <= '{ok: up_write,
               error_code: up_write ? pcc_pkg::ERR_NONE : pcc_pkg::ERR_FULL,
               updated: match_found,
               obstacle_count: (up_write && !match_found) ?
                   pcc_pkg::COUNT_W'(box_count + 1'b1) : pcc_pkg::COUNT_W'(box_count),
               default: '0};
    end else if (state == ST_VERD) begin
      res_kind <= pcc_pkg::KIND_VERDICT;
      res <= '{ok: v_pass,
               error_code: v_pass ? pcc_pkg::ERR_NONE : pcc_pkg::ERR_CLEARANCE,
               updated: 1'b0,
               obstacle_count: pcc_pkg::COUNT_W'(box_count),
               min_clearance_out: v_root,
               worst_obstacle: best_found ? best_id : '0,
               worst_point_index: best_found ? best_pidx : '0,
               worst_valid: best_found,
               point_count: points_seen};
    end

    if ((state == ST_FIN) && out_free) begin
      m_tdata <= {{PAD_W{1'b0}}, res};
      m_tuser <= res_kind;
    end
  end

  // ---------------------------------------------------------------- checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    box_count <= CNT_MAX)
    else $error("obstacle count above table depth");

  a_best_idle: assert property (@(posedge clk) disable iff (rst)
    !best_found |-> (best_sq == pcc_pkg::SQ_ALL_ONES))
    else $error("best distance changed without a hit");

  a_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(rd_v || a_v || b_v))
    else $error("scan pipe busy while taking a request");

  a_sqrt_found: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT) |-> best_found)
    else $error("square root started with no hit");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (issue_cnt <= box_count))
    else $error("scan read past the filled entries");

endmodule

`default_nettype wire

@@ tb/path_clearance_checker_unit_tb.sv @@
// Self-checking testbench for path_clearance_checker_unit: obstacle upserts, clears and
// path points go in on the request stream and are checked against a behavioral predictor.
// Depends on pcc_pkg and the checker RTL only.
`default_nettype none

module path_clearance_checker_unit_tb;
  import pcc_pkg::*;

  localparam int          MAX_BOXES      = 64;
  localparam int          STALL_LIMIT    = 20000;  // cycles without any handshake or config access
  localparam int          SETTLE_CYCLES  = 200;    // longer than the worst scan and root
  localparam logic [2:0]  MIN_CLEAR_ADDR = 3'd0;
  localparam logic [1:0]  OP_RESERVED    = 2'd3;   // block drops it silently
  localparam longint unsigned SQ_NONE    = 64'h0003_FFFF_FFFF_FFFF;

  // one request as driven: opcode on tuser, last point on tlast, the rest on tdata
  typedef struct {
    logic [1:0] op;
    box_entry_t body;
    logic       is_last;
  } request_t;

  typedef struct {
    logic [1:0] kind;
    result_t    res;
  } outcome_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [87:0]  m_tdata;
  logic [1:0]   m_tuser;

  always #2 clk = ~clk;

  path_clearance_checker_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  request_t pending_reqs[$];      // requests not yet accepted by the block
  outcome_t expected_results[$];  // predicted results, oldest first
  bit       req_presented = 0;    // pending_reqs[0] is on the bus
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       errors = 0;
  int       idle_cycles = 0;
  int       gen_count = 0;        // requests generated, reserved opcode excluded

  // ---------------------------------------------------------------------------
  // Predictor state: obstacle table, clearance threshold, running path state
  // ---------------------------------------------------------------------------
  box_entry_t      box_tbl[MAX_BOXES];
  int              n_boxes = 0;
  logic [23:0]     min_clear = '0;
  longint unsigned best_sq = SQ_NONE;
  logic [15:0]     best_id = '0;
  logic [15:0]     best_idx = '0;
  bit              best_hit = 0;
  logic [15:0]     pts_seen = '0;

  // squared gap past the box edge on one axis, zero inside the slab
  function automatic longint unsigned axis_sq_gap(logic signed [23:0] p,
                                                  logic signed [23:0] c,
                                                  logic signed [23:0] h);
    longint d;
    d = longint'(p) - longint'(c);
    if (d < 0) d = -d;
    d = d - longint'(h);
    return (d <= 0) ? 64'd0 : longint'(d * d);
  endfunction

  // floor square root, one result bit per step from the top
  function automatic logic [24:0] floor_root(longint unsigned v);
    logic [24:0]     r;
    longint unsigned t;
    r = '0;
    for (int b = 24; b >= 0; b--) begin
      t = longint'(r) | (64'd1 << b);
      if (t * t <= v) r = t[24:0];
    end
    return r;
  endfunction

  task automatic predict_request(request_t rq);
    outcome_t        o;
    box_entry_t      b;
    int              slot;
    logic [15:0]     idx;
    longint unsigned d2;
    logic [24:0]     root;
    bit              clear_ok;
    o.kind = rq.op;
    o.res = '0;
    case (rq.op)
      OP_UPSERT: begin
        b = rq.body;
        if (b.hx < MIN_HALF) b.hx = MIN_HALF;
        if (b.hy < MIN_HALF) b.hy = MIN_HALF;
        if (b.id == '0) begin
          o.res.error_code = ERR_EMPTY_ID;
        end else begin
          slot = -1;
          for (int i = 0; i < n_boxes; i++)
            if (slot < 0 && box_tbl[i].id == b.id) slot = i;
          if (slot >= 0) begin
            box_tbl[slot] = b;
            o.res.updated = 1'b1;
            o.res.ok = 1'b1;
          end else if (n_boxes >= MAX_BOXES) begin
            o.res.error_code = ERR_FULL;
          end else begin
            box_tbl[n_boxes] = b;
            n_boxes++;
            o.res.ok = 1'b1;
          end
        end
        o.res.obstacle_count = 7'(n_boxes);
        expected_results.push_back(o);
      end
      OP_CLEAR: begin
        // path progress survives; later points see an empty table
        n_boxes = 0;
        o.res.ok = 1'b1;
        expected_results.push_back(o);
      end
      OP_POINT: begin
        idx = pts_seen;
        if (pts_seen != 16'hFFFF) pts_seen++;
        // first and last points are never measured; strict < keeps earliest box/point
        if (idx != '0 && !rq.is_last) begin
          for (int i = 0; i < n_boxes; i++) begin
            d2 = axis_sq_gap(rq.body.cx, box_tbl[i].cx, box_tbl[i].hx) +
                 axis_sq_gap(rq.body.cy, box_tbl[i].cy, box_tbl[i].hy);
            if (d2 < best_sq) begin
              best_sq = d2;
              best_id = box_tbl[i].id;
              best_idx = idx;
              best_hit = 1;
            end
          end
        end
        if (rq.is_last) begin
          root = best_hit ? floor_root(best_sq) : '1;
          clear_ok = (min_clear == '0) || !best_hit || (root >= min_clear);
          o.res.ok = clear_ok;
          o.res.error_code = clear_ok ? ERR_NONE : ERR_CLEARANCE;
          o.res.obstacle_count = 7'(n_boxes);
          o.res.min_clearance_out = root;
          o.res.worst_obstacle = best_hit ? best_id : '0;
          o.res.worst_point_index = best_hit ? best_idx : '0;
          o.res.worst_valid = best_hit;
          o.res.point_count = pts_seen;
          expected_results.push_back(o);
          best_sq = SQ_NONE;
          best_id = '0;
          best_idx = '0;
          best_hit = 0;
          pts_seen = '0;
        end
      end
      default: ;  // reserved opcode: no result, no state change
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: inputs change on the falling edge. A presented request holds until
  // its handshake; sender gaps only fall between requests.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    if (!rst && !req_presented && pending_reqs.size() != 0 &&
        (send_idle_pct == 0 || $urandom_range(99) >= send_idle_pct)) begin
      s_tvalid <= 1'b1;
      s_tdata  <= pending_reqs[0].body;
      s_tuser  <= pending_reqs[0].op;
      s_tlast  <= pending_reqs[0].is_last;
      req_presented = 1;
    end else if (!req_presented) begin
      s_tvalid <= 1'b0;
    end
  end

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: results are checked against the oldest prediction, then an
  // accepted request is fed to the predictor.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t e;
    result_t  got;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[84:0]);
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: kind %0d", m_tuser);
        errors++;
      end else begin
        e = expected_results.pop_front();
        check_field("kind", e.kind, m_tuser);
        check_field("ok", e.res.ok, got.ok);
        check_field("error_code", e.res.error_code, got.error_code);
        check_field("updated", e.res.updated, got.updated);
        check_field("obstacle_count", e.res.obstacle_count, got.obstacle_count);
        check_field("min_clearance_out", e.res.min_clearance_out, got.min_clearance_out);
        check_field("worst_obstacle", e.res.worst_obstacle, got.worst_obstacle);
        check_field("worst_point_index", e.res.worst_point_index, got.worst_point_index);
        check_field("worst_valid", e.res.worst_valid, got.worst_valid);
        check_field("point_count", e.res.point_count, got.point_count);
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      predict_request(pending_reqs[0]);
      void'(pending_reqs.pop_front());
      req_presented = 0;
    end
  end

  // watchdog: any handshake or config access counts as progress
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $error("no progress for %0d cycles", STALL_LIMIT);
      $display("path_clearance_checker_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_req(logic [1:0] op, logic [15:0] id, logic signed [23:0] x,
                         logic signed [23:0] y, logic signed [23:0] hx,
                         logic signed [23:0] hy, logic is_last);
    request_t rq;
    rq.op = op;
    rq.body.id = id;
    rq.body.cx = x;
    rq.body.cy = y;
    rq.body.hx = hx;
    rq.body.hy = hy;
    rq.is_last = is_last;
    pending_reqs.push_back(rq);
    if (op != OP_RESERVED) gen_count++;
  endtask

  // mostly a working area around the origin, sometimes anywhere in range
  function automatic logic signed [23:0] rand_coord();
    int v;
    if ($urandom_range(99) < 15) return 24'($urandom);
    v = int'($urandom_range(24000)) - 12000;
    return v[23:0];
  endfunction

  // full range (negatives clamp), around the 1 cm floor, or ordinary sizes
  function automatic logic signed [23:0] rand_half();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 15) return 24'($urandom);
    if (r < 25) begin
      v = int'($urandom_range(40)) - 20;
      return v[23:0];
    end
    return 24'($urandom_range(2000));
  endfunction

  // small pool so updates happen often; sometimes the empty id or any id
  function automatic logic [15:0] rand_id();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 15) return 16'($urandom);
    return 16'($urandom_range(24, 1));
  endfunction

  task automatic add_rand_upsert();
    add_req(OP_UPSERT, rand_id(), rand_coord(), rand_coord(), rand_half(), rand_half(),
            1'($urandom));
  endtask

  // well-formed path, with occasional table traffic or junk in the middle
  task automatic add_rand_path(int len);
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (i > 0 && r < 6) add_rand_upsert();
      else if (i > 0 && r < 8) add_req(OP_CLEAR, 16'($urandom), rand_coord(), rand_coord(),
                                       rand_half(), rand_half(), 1'($urandom));
      else if (i > 0 && r < 11) add_req(OP_RESERVED, 16'($urandom), rand_coord(),
                                        rand_coord(), rand_half(), rand_half(), 1'($urandom));
      add_req(OP_POINT, 16'($urandom), rand_coord(), rand_coord(), rand_half(), rand_half(),
              i == len - 1);
    end
  endtask

  // fill the table to capacity, overflow it, update when full, then walk a path
  task automatic add_full_table();
    add_req(OP_CLEAR, '0, '0, '0, '0, '0, 1'b0);
    for (int i = 0; i < MAX_BOXES; i++)
      add_req(OP_UPSERT, 16'h0100 + 16'(i), rand_coord(), rand_coord(), rand_half(),
              rand_half(), 1'b0);
    add_req(OP_UPSERT, 16'h0200, rand_coord(), rand_coord(), rand_half(), rand_half(), 1'b0);
    add_req(OP_UPSERT, 16'h0105, rand_coord(), rand_coord(), rand_half(), rand_half(), 1'b0);
    add_rand_path(4);
    add_req(OP_CLEAR, '0, '0, '0, '0, '0, 1'b0);
  endtask

  task automatic add_rand_phase(int target);
    int base;
    int r;
    base = gen_count;
    add_full_table();
    while (gen_count - base < target) begin
      r = $urandom_range(99);
      if (r < 30) add_rand_upsert();
      else if (r < 35) add_req(OP_CLEAR, 16'($urandom), rand_coord(), rand_coord(),
                               rand_half(), rand_half(), 1'($urandom));
      else if (r < 38) add_req(OP_RESERVED, 16'($urandom), rand_coord(), rand_coord(),
                               rand_half(), rand_half(), 1'($urandom));
      else if (r < 42) add_req(OP_POINT, 16'($urandom), rand_coord(), rand_coord(),
                               rand_half(), rand_half(), 1'($urandom));
      else if (r < 45) add_rand_path($urandom_range(40, 20));
      else add_rand_path($urandom_range(8, 1));
    end
  endtask

  // wait for every request and result, then give the last no-result point time
  task automatic settle();
    while (pending_reqs.size() != 0 || req_presented || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write the threshold, then read it back
  task automatic set_min_clearance(logic [23:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= MIN_CLEAR_ADDR; pwdata <= {8'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    min_clear = value;
    @(negedge clk);
    penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", {8'd0, value}, prdata);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, threshold still at reset (check disabled)
    add_req(OP_POINT, '0, 24'sd5, 24'sd5, '0, '0, 1'b1);             // one-point path
    add_req(OP_UPSERT, '0, 24'sd100, 24'sd100, 24'sd50, 24'sd50, 1'b0); // empty id
    add_req(OP_UPSERT, 16'd5, '0, '0, -24'sd5, '0, 1'b0);            // halves clamp to 1 cm
    add_req(OP_UPSERT, 16'd5, '0, '0, 24'sd160, 24'sd160, 1'b0);     // overwrite
    add_req(OP_UPSERT, 16'hFFFF, 24'h800000, 24'h7FFFFF, 24'sd16, 24'sd16, 1'b0);
    add_req(OP_POINT, '0, '0, '0, '0, '0, 1'b0);
    add_req(OP_POINT, '0, 24'sd1000, '0, '0, '0, 1'b0);
    add_req(OP_POINT, '0, 24'h800000, 24'h7FFFFF, '0, '0, 1'b0);      // touches corner box
    add_req(OP_RESERVED, 16'hFFFF, '1, '1, '1, '1, 1'b1);
    add_req(OP_POINT, '0, 24'h7FFFFF, 24'h800000, '0, '0, 1'b1);
    settle();

    set_min_clearance(24'd800);
    add_req(OP_POINT, '0, 24'sd30000, '0, '0, '0, 1'b0);
    add_req(OP_POINT, '0, 24'sd500, '0, '0, '0, 1'b0);              // violates 50 cm
    add_req(OP_POINT, '0, '0, '0, '0, '0, 1'b1);                    // last is not measured
    add_req(OP_UPSERT, 16'd7, 24'sd2000, '0, 24'sd160, 24'sd160, 1'b0);
    add_req(OP_POINT, '0, '0, '0, '0, '0, 1'b0);
    add_req(OP_POINT, '0, 24'sd1000, '0, '0, '0, 1'b0);             // tie, earlier box wins
    add_req(OP_CLEAR, '0, '0, '0, '0, '0, 1'b0);                    // clear mid-path
    add_req(OP_POINT, '0, '0, '0, '0, '0, 1'b0);                    // empty table
    add_req(OP_POINT, '0, '0, '0, '0, '0, 1'b1);
    add_req(OP_POINT, '0, 24'sd10, '0, '0, '0, 1'b0);
    add_req(OP_POINT, '0, 24'sd20, '0, '0, '0, 1'b1);               // nothing measured
    add_req(OP_UPSERT, 16'd9, '0, '0, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
    add_req(OP_POINT, '0, '0, '0, '0, '0, 1'b0);
    add_req(OP_POINT, '0, 24'sd100, 24'sd100, '0, '0, 1'b0);        // inside the box
    add_req(OP_POINT, '0, '0, '0, '0, '0, 1'b1);
    settle();

    // phase 0: no idling; includes a path long enough to saturate the index
    send_idle_pct = 0; recv_stall_pct = 0;
    set_min_clearance(24'($urandom_range(4000, 1)));
    add_req(OP_CLEAR, '0, '0, '0, '0, '0, 1'b0);
    for (int i = 0; i < 65540; i++)
      add_req(OP_POINT, '0, 24'($urandom), 24'($urandom), '0, '0, 1'b0);
    add_req(OP_UPSERT, 16'd3, '0, '0, 24'sd16, 24'sd16, 1'b0);
    add_req(OP_POINT, '0, 24'sd116, '0, '0, '0, 1'b0);              // checked at index 65535
    add_req(OP_POINT, '0, '0, '0, '0, '0, 1'b1);
    add_req(OP_CLEAR, '0, '0, '0, '0, '0, 1'b0);
    add_rand_phase(225);
    settle();

    // phase 1: sender mostly idle, strictest threshold
    send_idle_pct = 86; recv_stall_pct = 0;
    set_min_clearance(24'hFFFFFF);
    add_rand_phase(225);
    settle();

    // phase 2: receiver mostly stalled, check disabled
    send_idle_pct = 0; recv_stall_pct = 86;
    set_min_clearance(24'd0);
    add_rand_phase(225);
    settle();

    // phase 3: light idling on both sides
    send_idle_pct = 10; recv_stall_pct = 10;
    set_min_clearance(24'($urandom_range(6000, 1)));
    add_rand_phase(225);
    settle();

    if (errors == 0 && expected_results.size() == 0)
      $display("path_clearance_checker_unit regression: pass");
    else
      $display("path_clearance_checker_unit regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
